// ===== rtl/swm_pkg.sv =====
// Package for the sliding window median filter: sizes, payload types,
// register indexes, the controller state type and the cell control word.
// Depends on nothing; every other file of the block refers to it.
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 30;
  localparam int IDX_BITS    = $clog2(WINDOW_MAX);
  localparam int SIZE_BITS   = IDX_BITS + 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [SIZE_BITS-1:0]   size_t;

  localparam size_t FILL_MAX   = size_t'(WINDOW_MAX);
  localparam size_t SIZE_RESET = size_t'(3);

  // Configuration port.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = SIZE_BITS;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
  localparam cfg_idx_t REG_WINDOW_SIZE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_EVEN_MODE   = cfg_idx_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COUNT,
    ST_PICK,
    ST_SEND
  } state_e;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;  // a new word enters, every sample moves one cell older
    logic load;   // copy neighbor samples into the probe lines, clear ranks
    logic count;  // compare against the probes, then move the probes on
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// One cell of the sample chain: a sample register, two probe registers that
// travel in opposite directions, and a rank counter.
// Depends on swm_pkg.
`default_nettype none

module swm_cell (
  input  wire                  clk_i,
  input  swm_pkg::cell_ctrl_t  ctrl_i,
  input  swm_pkg::idx_t        idx_i,
  input  swm_pkg::size_t       k_i,
  input  swm_pkg::sample_t     sample_prev_i,
  input  swm_pkg::sample_t     sample_next_i,
  input  swm_pkg::sample_t     up_prev_i,
  input  logic                 up_prev_vld_i,
  input  swm_pkg::sample_t     dn_next_i,
  input  logic                 dn_next_vld_i,
  output swm_pkg::sample_t     sample_o,
  output swm_pkg::sample_t     up_o,
  output logic                 up_vld_o,
  output swm_pkg::sample_t     dn_o,
  output logic                 dn_vld_o,
  output swm_pkg::idx_t        rank_o,
  output logic                 inwin_o
);

  swm_pkg::sample_t sample_d, sample_q;
  swm_pkg::sample_t up_d, up_q, dn_d, dn_q;
  logic             up_vld_d, up_vld_q, dn_vld_d, dn_vld_q;
  swm_pkg::idx_t    rank_d, rank_q;
  swm_pkg::size_t   idx_ext;
  logic             inc_up, inc_dn;

  assign idx_ext = {1'b0, idx_i};

  // Ties are broken by age so that every sample has a rank of its own:
  // a newer equal sample (up line) ranks below this one, an older one above.
  assign inc_dn = dn_vld_q && (dn_q < sample_q);
  assign inc_up = up_vld_q && (up_q <= sample_q);

  always_comb begin
    sample_d = sample_q;
    up_d     = up_q;
    up_vld_d = up_vld_q;
    dn_d     = dn_q;
    dn_vld_d = dn_vld_q;
    rank_d   = rank_q;
    if (ctrl_i.shift) begin
      sample_d = sample_prev_i;
    end
    if (ctrl_i.load) begin
      dn_d     = sample_next_i;
      dn_vld_d = (idx_ext + swm_pkg::size_t'(1)) < k_i;
      up_d     = sample_prev_i;
      up_vld_d = (idx_i != '0) && (idx_ext <= k_i);
      rank_d   = '0;
    end else if (ctrl_i.count) begin
      rank_d   = rank_q + {{(swm_pkg::IDX_BITS-1){1'b0}}, inc_dn}
                        + {{(swm_pkg::IDX_BITS-1){1'b0}}, inc_up};
      dn_d     = dn_next_i;
      dn_vld_d = dn_next_vld_i;
      up_d     = up_prev_i;
      up_vld_d = up_prev_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    up_q     <= up_d;
    up_vld_q <= up_vld_d;
    dn_q     <= dn_d;
    dn_vld_q <= dn_vld_d;
    rank_q   <= rank_d;
  end

  assign sample_o = sample_q;
  assign up_o     = up_q;
  assign up_vld_o = up_vld_q;
  assign dn_o     = dn_q;
  assign dn_vld_o = dn_vld_q;
  assign rank_o   = rank_q;
  assign inwin_o  = idx_ext < k_i;

endmodule

`default_nettype wire

// ===== rtl/swm_pick.sv =====
// Picks the middle sample(s) of the window by rank and forms the median.
// Depends on swm_pkg.
`default_nettype none

module swm_pick (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  logic                       capture_i,
  input  swm_pkg::size_t             k_i,
  input  logic                       even_mode_i,
  input  swm_pkg::sample_t           samples_i [swm_pkg::WINDOW_MAX],
  input  swm_pkg::idx_t              ranks_i   [swm_pkg::WINDOW_MAX],
  input  logic [swm_pkg::WINDOW_MAX-1:0] inwin_i,
  output swm_pkg::sample_t           median_o
);

  swm_pkg::idx_t    hi_tgt, lo_tgt;
  logic [swm_pkg::WINDOW_MAX-1:0] hit_hi, hit_lo;
  swm_pkg::sample_t hi_d, hi_q, lo_d, lo_q;
  logic [swm_pkg::SAMPLE_BITS:0] pair_sum;

  assign hi_tgt = k_i[swm_pkg::SIZE_BITS-1:1];
  assign lo_tgt = hi_tgt - swm_pkg::idx_t'(1);

  always_comb begin
    hi_d = '0;
    lo_d = '0;
    for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
      hit_hi[j] = inwin_i[j] && (ranks_i[j] == hi_tgt);
      hit_lo[j] = inwin_i[j] && (ranks_i[j] == lo_tgt);
      hi_d = hi_d | (samples_i[j] & {swm_pkg::SAMPLE_BITS{hit_hi[j]}});
      lo_d = lo_d | (samples_i[j] & {swm_pkg::SAMPLE_BITS{hit_lo[j]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign pair_sum = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    if (k_i[0]) begin
      median_o = hi_q;
    end else if (even_mode_i) begin
      median_o = pair_sum[swm_pkg::SAMPLE_BITS:1];
    end else begin
      median_o = lo_q;
    end
  end

  a_hi_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture_i |-> $onehot(hit_hi))
    else $error("upper middle rank is not held by exactly one cell");

  a_lo_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (capture_i && !k_i[0]) |-> $onehot(hit_lo))
    else $error("lower middle rank is not held by exactly one cell");

  a_window_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture_i |-> ($countones(inwin_i) == int'(k_i)))
    else $error("window mask does not match the window size");

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median_top.sv =====
// A word that completes the window gives its median after the load step, the
// k-1 compare steps of the probe lines in the cell chain, the pick step and
// the send step (k = window size); a word that leaves the window short gives
// no result and the next word is taken in the next cycle. A new word is only
// taken once the median of the last one has gone to the output register.
// Reset: asynchronous, active low; empties the window, window size 3, mode 0.
// Top level of the sliding window median filter. Uses swm_pkg, swm_cell and
// swm_pick.
`default_nettype none

module sliding_window_median_top (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // Sample channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  swm_pkg::sample_t         sample_i,
  input  logic                     restart_i,
  // Result channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output swm_pkg::sample_t         median_o,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  swm_pkg::cfg_idx_t        cfg_index_i,
  input  swm_pkg::cfg_data_t       cfg_data_i
);

  localparam int N = swm_pkg::WINDOW_MAX;

  // The samples live in a chain of cells in arrival order: cell 0 holds the
  // newest word and cell j the one that arrived j words earlier. A restart
  // only resets the fill count, so older cells simply fall out of the window
  // until they are overwritten by new words.
  //
  // To find the median every cell computes the rank of its own sample among
  // the first k cells. Two probe lines are loaded from the neighbors and then
  // move one cell per cycle, one toward older and one toward newer cells, so
  // after k-1 steps each cell has seen every other sample of the window. The
  // pick unit then selects the cells whose rank is k/2 and k/2-1.

  swm_pkg::state_e    state_q, state_d;
  swm_pkg::idx_t      cnt_q, cnt_d;
  swm_pkg::size_t     fill_q, fill_d;
  swm_pkg::size_t     wsize_q, wsize_d;
  logic               mode_q, mode_d;
  logic               out_valid_q, out_valid_d;
  swm_pkg::sample_t   median_q, median_d;

  swm_pkg::size_t     k_eff;
  swm_pkg::size_t     fill_next;
  logic               in_accept;
  logic               out_room;
  swm_pkg::cell_ctrl_t cell_ctrl;
  logic               capture;
  swm_pkg::sample_t   pick_median;

  swm_pkg::sample_t   cell_sample [N];
  swm_pkg::sample_t   cell_up     [N];
  swm_pkg::sample_t   cell_dn     [N];
  logic [N-1:0]       cell_up_vld;
  logic [N-1:0]       cell_dn_vld;
  swm_pkg::idx_t      cell_rank   [N];
  logic [N-1:0]       cell_inwin;

  // Out-of-range window sizes are clamped to 1..WINDOW_MAX.
  always_comb begin
    if (wsize_q == '0) begin
      k_eff = swm_pkg::size_t'(1);
    end else if (wsize_q > swm_pkg::FILL_MAX) begin
      k_eff = swm_pkg::FILL_MAX;
    end else begin
      k_eff = wsize_q;
    end
  end

  // Config regs. Writes must only come while the filter is idle; unenforced.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    wsize_d = wsize_q;
    mode_d  = mode_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        swm_pkg::REG_WINDOW_SIZE: begin
          wsize_d = cfg_data_i;
        end
        swm_pkg::REG_EVEN_MODE: begin
          mode_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // A word is taken only while the sequencer is idle. A finished median may
  // still wait in the output register at that time.
  assign in_stall_o = (state_q != swm_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_room   = !out_valid_q || !out_stall_i;

  // Fill count of the current sequence, saturating at the chain length.
  always_comb begin
    if (restart_i) begin
      fill_next = swm_pkg::size_t'(1);
    end else if (fill_q >= swm_pkg::FILL_MAX) begin
      fill_next = fill_q;
    end else begin
      fill_next = fill_q + swm_pkg::size_t'(1);
    end
  end

  // Sequencer: idle, load the probes, k-1 compare steps, pick, send.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    median_d    = median_q;
    cell_ctrl   = '0;
    capture     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      swm_pkg::ST_IDLE: begin
        if (in_accept) begin
          cell_ctrl.shift = 1'b1;
          fill_d          = fill_next;
          if (fill_next >= k_eff) begin
            state_d = swm_pkg::ST_LOAD;
          end
        end
      end
      swm_pkg::ST_LOAD: begin
        cell_ctrl.load = 1'b1;
        cnt_d          = '0;
        if (k_eff == swm_pkg::size_t'(1)) begin
          state_d = swm_pkg::ST_PICK;
        end else begin
          state_d = swm_pkg::ST_COUNT;
        end
      end
      swm_pkg::ST_COUNT: begin
        cell_ctrl.count = 1'b1;
        if (swm_pkg::size_t'(cnt_q) + swm_pkg::size_t'(2) == k_eff) begin
          state_d = swm_pkg::ST_PICK;
        end else begin
          cnt_d = cnt_q + swm_pkg::idx_t'(1);
        end
      end
      swm_pkg::ST_PICK: begin
        capture = 1'b1;
        state_d = swm_pkg::ST_SEND;
      end
      swm_pkg::ST_SEND: begin
        if (out_room) begin
          out_valid_d = 1'b1;
          median_d    = pick_median;
          state_d     = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swm_pkg::ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      wsize_q     <= swm_pkg::SIZE_RESET;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      wsize_q     <= wsize_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    median_q <= median_d;
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  // The cell chain. The ends are tied off: the newest cell takes the input
  // word, and probes beyond either end arrive marked invalid.
  for (genvar j = 0; j < N; j++) begin : g_cell
    swm_pkg::sample_t s_prev, s_next, u_prev, d_next;
    logic             u_prev_vld, d_next_vld;

    if (j == 0) begin : g_first
      assign s_prev     = sample_i;
      assign u_prev     = '0;
      assign u_prev_vld = 1'b0;
    end else begin : g_mid_lo
      assign s_prev     = cell_sample[j-1];
      assign u_prev     = cell_up[j-1];
      assign u_prev_vld = cell_up_vld[j-1];
    end

    if (j == N-1) begin : g_last
      assign s_next     = '0;
      assign d_next     = '0;
      assign d_next_vld = 1'b0;
    end else begin : g_mid_hi
      assign s_next     = cell_sample[j+1];
      assign d_next     = cell_dn[j+1];
      assign d_next_vld = cell_dn_vld[j+1];
    end

    swm_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .idx_i         (swm_pkg::idx_t'(j)),
      .k_i           (k_eff),
      .sample_prev_i (s_prev),
      .sample_next_i (s_next),
      .up_prev_i     (u_prev),
      .up_prev_vld_i (u_prev_vld),
      .dn_next_i     (d_next),
      .dn_next_vld_i (d_next_vld),
      .sample_o      (cell_sample[j]),
      .up_o          (cell_up[j]),
      .up_vld_o      (cell_up_vld[j]),
      .dn_o          (cell_dn[j]),
      .dn_vld_o      (cell_dn_vld[j]),
      .rank_o        (cell_rank[j]),
      .inwin_o       (cell_inwin[j])
    );
  end

  swm_pick u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capture_i   (capture),
    .k_i         (k_eff),
    .even_mode_i (mode_q),
    .samples_i   (cell_sample),
    .ranks_i     (cell_rank),
    .inwin_i     (cell_inwin),
    .median_o    (pick_median)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swm_pkg::ST_COUNT) |->
      (swm_pkg::size_t'(cnt_q) + swm_pkg::size_t'(2) <= k_eff))
    else $error("compare step count ran past the window size");

  a_load_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swm_pkg::ST_LOAD) |-> (fill_q >= k_eff))
    else $error("median started on a window that is not full");

  a_send_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == swm_pkg::ST_SEND))
    else $error("result word appeared without a send step");

endmodule

`default_nettype wire

// ===== sim/tb_sliding_window_median_top.sv =====
// Self-checking testbench for sliding_window_median_top: directed and random sample
// words under several idle and stall profiles and window settings.
// Depends on swm_pkg and the RTL of the filter only.
`timescale 1ns / 1ps

module tb_sliding_window_median_top;

  // Cycles without any handshake before the run is declared hung. The slowest
  // correct gap is a full 64-sample window under heavy receiver stalls.
  localparam int QUIET_LIMIT = 4000;
  // Cycles to let pass once nothing is due, so that a word that left the
  // window short has surely been absorbed.
  localparam int SETTLE_CYCLES = swm_pkg::WINDOW_MAX + 8;
  localparam int NUM_PHASES = 17;
  localparam swm_pkg::sample_t TOP_SAMPLE = '1;

  typedef struct packed {
    swm_pkg::sample_t sample;
    logic             restart;
  } word_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  swm_pkg::sample_t   sample_i = '0;
  logic               restart_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  swm_pkg::sample_t   median_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  swm_pkg::cfg_idx_t  cfg_index_i = '0;
  swm_pkg::cfg_data_t cfg_data_i = '0;

  sliding_window_median_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .median_o    (median_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Words queued by the stimulus process and medians the filter still owes.
  word_t            words_waiting [$];
  swm_pkg::sample_t medians_due [$];

  // Percentages for the current idle profile.
  int sender_idle_pct = 0;
  int stall_pct = 0;

  int   mismatches = 0;
  int   quiet_cycles = 0;
  logic in_took = 1'b0;

  // Shadow of the filter: the sample history, the fill level since the last
  // restart, the next ring slot and the two registers.
  swm_pkg::sample_t   history [swm_pkg::WINDOW_MAX];
  int unsigned        held_count = 0;
  swm_pkg::idx_t      next_slot = '0;
  swm_pkg::cfg_data_t size_reg = swm_pkg::cfg_data_t'(swm_pkg::SIZE_RESET);
  logic               mode_reg = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A size of zero behaves as one, and anything past the ring depth as the
  // full ring.
  function automatic int clamp_size(input swm_pkg::cfg_data_t s);
    if (s == 0) return 1;
    if (s > swm_pkg::WINDOW_MAX) return swm_pkg::WINDOW_MAX;
    return int'(s);
  endfunction

  // Stores one sample in the shadow history and, if the window is full,
  // returns 1 with the median that the filter must produce for it.
  function automatic bit filter_median(input swm_pkg::sample_t s, input logic fresh,
                                       output swm_pkg::sample_t med);
    swm_pkg::sample_t win [swm_pkg::WINDOW_MAX];
    swm_pkg::sample_t x;
    logic [swm_pkg::SAMPLE_BITS:0] sum;
    swm_pkg::idx_t p;
    int k, i, j;
    if (fresh) begin
      held_count = 0;
      next_slot = '0;
    end
    history[next_slot] = s;
    next_slot = next_slot + 1'b1;
    if (held_count < swm_pkg::WINDOW_MAX) held_count++;
    k = clamp_size(size_reg);
    med = '0;
    if (held_count < k) return 1'b0;
    // Gather the newest k samples, oldest first.
    p = next_slot;
    for (i = 0; i < k; i++) begin
      p = p - 1'b1;
      win[k-1-i] = history[p];
    end
    for (i = 1; i < k; i++) begin
      x = win[i];
      j = i;
      while (j > 0 && win[j-1] > x) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = x;
    end
    if (k % 2 == 1) begin
      med = win[k/2];
    end else if (!mode_reg) begin
      med = win[k/2-1];
    end else begin
      // One extra bit keeps the sum of two top-range samples from wrapping.
      sum = {1'b0, win[k/2-1]} + {1'b0, win[k/2]};
      med = sum[swm_pkg::SAMPLE_BITS:1];
    end
    return 1'b1;
  endfunction

  // Sender. A new word is put up at the falling edge only when the slot is
  // free, that is, nothing is shown or the word shown was taken at the last
  // rising edge. A word that is stalled keeps its payload untouched.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (words_waiting.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        word_t w;
        w = words_waiting.pop_front();
        sample_i   <= w.sample;
        restart_i  <= w.restart;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stalls, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Monitor. Everything is sampled at the rising edge: accepted sample words
  // feed the shadow filter, accepted register writes update its registers,
  // and accepted results are checked against the oldest median due.
  always @(posedge clk_i) begin
    bit               in_fire, out_fire, cfg_fire;
    swm_pkg::sample_t due;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;
    in_took <= in_fire;

    if (out_fire) begin
      if (medians_due.size() == 0) begin
        $error("median word with nothing due: actual %0d", median_o);
        mismatches++;
      end else begin
        due = medians_due.pop_front();
        if (median_o !== due) begin
          $error("median mismatch: expected %0d, actual %0d", due, median_o);
          mismatches++;
        end
      end
    end

    if (in_fire && filter_median(sample_i, restart_i, due)) medians_due = {medians_due, due};

    if (cfg_fire) begin
      if (cfg_index_i == swm_pkg::REG_WINDOW_SIZE) size_reg = cfg_data_i;
      else if (cfg_index_i == swm_pkg::REG_EVEN_MODE) mode_reg = cfg_data_i[0];
    end

    // Watchdog on handshakes of any kind.
    if (!rst_ni || in_fire || out_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_sliding_window_median_top NOT OK");
        $finish;
      end
    end
  end

  task automatic push_word(input swm_pkg::sample_t s, input logic r);
    word_t w;
    w.sample  = s;
    w.restart = r;
    words_waiting = {words_waiting, w};
  endtask

  // Waits until every queued word has been taken and every median has come
  // back, then lets the filter settle on words that gave no result.
  task automatic drain();
    while (words_waiting.size() != 0 || in_valid_i || medians_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input swm_pkg::cfg_idx_t idx,
                                input swm_pkg::cfg_data_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_profile(input int p);
    case (p)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 78; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 78; end
      default: begin sender_idle_pct = 28; stall_pct = 28; end
    endcase
  endtask

  // Sample flavors: full range, a tiny range full of ties, values crowding the
  // top of the range, and a mix of both extremes with random values.
  function automatic swm_pkg::sample_t pick_sample(input int style);
    case (style)
      0: return swm_pkg::sample_t'($urandom);
      1: return swm_pkg::sample_t'($urandom_range(7));
      2: return TOP_SAMPLE - swm_pkg::sample_t'($urandom_range(3));
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return TOP_SAMPLE;
          default: return swm_pkg::sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Mostly sequences that open with a restart and run well past a full
  // window; some stop short of filling it, and a few carry stray restarts.
  // The first sequence may skip its restart, so a new size is applied over
  // the samples left from the previous phase.
  task automatic queue_random(input int count, input int k);
    int made, len, style, i;
    bit fresh, noisy;
    made = 0;
    fresh = $urandom_range(1);
    while (made < count) begin
      style = $urandom_range(3);
      if ($urandom_range(9) < 8) len = k + $urandom_range(2 * k + 4);
      else len = (k > 1) ? $urandom_range(k - 1, 1) : 1;
      noisy = ($urandom_range(9) == 0);
      for (i = 0; i < len && made < count; i++) begin
        push_word(pick_sample(style), (i == 0) ? fresh : (noisy && $urandom_range(7) == 0));
        made++;
      end
      fresh = 1'b1;
    end
  endtask

  // Window size, even rule and word count of each random phase. The sizes
  // include zero and values past the ring depth, which the filter clamps.
  task automatic phase_plan(input int ph, output int size, output int mode, output int count);
    case (ph)
      0:  begin size = 1;   mode = 0; count = 120; end
      1:  begin size = 2;   mode = 0; count = 120; end
      2:  begin size = 2;   mode = 1; count = 120; end
      3:  begin size = 3;   mode = 1; count = 150; end
      4:  begin size = 4;   mode = 0; count = 120; end
      5:  begin size = 4;   mode = 1; count = 120; end
      6:  begin size = 5;   mode = 0; count = 120; end
      7:  begin size = 64;  mode = 1; count = 60;  end
      8:  begin size = 0;   mode = 1; count = 80;  end
      9:  begin size = 127; mode = 0; count = 50;  end
      10: begin size = 8;   mode = 1; count = 120; end
      11: begin size = 6;   mode = 0; count = 120; end
      12: begin size = 7;   mode = 1; count = 120; end
      13: begin size = 16;  mode = 1; count = 100; end
      14: begin size = 32;  mode = 0; count = 60;  end
      15: begin size = 10;  mode = 1; count = 120; end
      default: begin size = 3; mode = 0; count = 100; end
    endcase
  endtask

  initial begin
    int ph, size, mode, count, k;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_profile(0);

    // Reset settings: window of three, lower middle rule. Extremes of the
    // sample range, then a restart in the middle of a running sequence.
    push_word('0, 1'b1);
    push_word(TOP_SAMPLE, 1'b0);
    push_word(TOP_SAMPLE, 1'b0);
    push_word('0, 1'b0);
    push_word(swm_pkg::sample_t'(1), 1'b0);
    push_word(TOP_SAMPLE - 1'b1, 1'b0);
    push_word(swm_pkg::sample_t'(5), 1'b1);
    push_word(swm_pkg::sample_t'(7), 1'b0);
    push_word(swm_pkg::sample_t'(6), 1'b0);
    drain();

    // Even window with the average rule: two top-range middles must not
    // wrap, and an odd sum rounds down.
    write_register(swm_pkg::REG_WINDOW_SIZE, swm_pkg::cfg_data_t'(2));
    write_register(swm_pkg::REG_EVEN_MODE, swm_pkg::cfg_data_t'(1));
    push_word(TOP_SAMPLE, 1'b1);
    push_word(TOP_SAMPLE, 1'b0);
    push_word(TOP_SAMPLE - 1'b1, 1'b0);
    push_word('0, 1'b0);
    push_word(swm_pkg::sample_t'(1), 1'b1);
    push_word(swm_pkg::sample_t'(2), 1'b0);
    drain();

    write_register(swm_pkg::REG_EVEN_MODE, swm_pkg::cfg_data_t'(0));
    push_word(swm_pkg::sample_t'(3), 1'b0);
    drain();

    // A window of one answers on the very word that restarts.
    write_register(swm_pkg::REG_WINDOW_SIZE, swm_pkg::cfg_data_t'(1));
    push_word(swm_pkg::sample_t'(9), 1'b1);
    push_word(TOP_SAMPLE, 1'b0);
    drain();

    // Growing the window mid-sequence: silent until four samples are held.
    write_register(swm_pkg::REG_WINDOW_SIZE, swm_pkg::cfg_data_t'(4));
    push_word(swm_pkg::sample_t'(4), 1'b0);
    push_word('0, 1'b0);
    push_word(swm_pkg::sample_t'(2), 1'b0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      phase_plan(ph, size, mode, count);
      write_register(swm_pkg::REG_WINDOW_SIZE, swm_pkg::cfg_data_t'(size));
      write_register(swm_pkg::REG_EVEN_MODE, swm_pkg::cfg_data_t'(mode));
      set_profile(ph % 4);
      k = clamp_size(swm_pkg::cfg_data_t'(size));
      if (ph % 3 == 0) begin
        // The sender holds back halfway until the filter has caught up.
        queue_random(count / 2, k);
        drain();
        queue_random(count - count / 2, k);
      end else begin
        queue_random(count, k);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_sliding_window_median_top OK");
    end else begin
      $display("tb_sliding_window_median_top NOT OK");
    end
    $finish;
  end

endmodule
